// ----- sv/eight_bit_register_machine_execute_defines.svh -----
// Assertion macros for the register machine execute unit.
// Used by eight_bit_register_machine_execute.sv; expects clk and arst_n in scope.
`ifndef EIGHT_BIT_REGISTER_MACHINE_EXECUTE_DEFINES_SVH
`define EIGHT_BIT_REGISTER_MACHINE_EXECUTE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define EBRM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define EBRM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ebrm_pkg.sv -----
// Shared types and constants of the register machine execute unit.
// No dependencies.
package ebrm_pkg;

	localparam int DATA_W = 8;
	localparam int WORD_W = 16;
	// widest intermediate: 8-bit unsigned times 16-bit signed
	localparam int FULL_W = 25;
	localparam int DIV_W  = 16;
	localparam int CNT_W  = 5;

	typedef enum logic [3:0] {
		CMD_IN    = 4'd0,
		CMD_OUT   = 4'd1,
		CMD_MOV   = 4'd2,
		CMD_ADD   = 4'd3,
		CMD_SUB   = 4'd4,
		CMD_MUL   = 4'd5,
		CMD_DIV   = 4'd6,
		CMD_INC   = 4'd7,
		CMD_DEC   = 4'd8,
		CMD_ROL   = 4'd9,
		CMD_ROR   = 4'd10,
		CMD_SHL   = 4'd11,
		CMD_SHR   = 4'd12,
		CMD_LOAD  = 4'd13,
		CMD_STORE = 4'd14
	} ebrm_cmd_t;

	typedef enum logic [1:0] {
		SRC_REG = 2'd0,
		SRC_IMM = 2'd1,
		SRC_MEM = 2'd2
	} ebrm_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GET_D,
		ST_GET_S,
		ST_ADDR_DIV,
		ST_MEM_RD,
		ST_MEM_DATA,
		ST_SRC,
		ST_QUO_DIV,
		ST_ALU,
		ST_EXEC
	} ebrm_state_t;

endpackage

// ----- sv/ebrm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ebrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/eight_bit_register_machine_execute.sv -----
// Execute unit of a small 8-bit register machine: register file and data memory in RAMs.
// Depends on ebrm_pkg, ebrm_ram and eight_bit_register_machine_execute_defines.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_stall  | command dest_reg src_kind src_reg immediate
//           |                      | shift_count io_value
//   out     | out_valid / out_stall| out_value overflow underflow carry zero
//           |                      | div_error step_count
//
// One item at a time. A plain item passes through two register file reads,
// operand select, ALU and commit before the next accept. A memory operand or
// LOAD/STORE adds the data memory read, plus the address remainder in the
// divider when MEM_WORDS is not a power of two. DIV adds the quotient steps in the
// shared shift-subtract divider. Reset needs no clearing pass: per-entry valid
// bits make unwritten entries read as zero. A result waiting on out_stall holds
// commit until the output register frees; no new item is accepted meanwhile.
`include "eight_bit_register_machine_execute_defines.svh"

module eight_bit_register_machine_execute
	import ebrm_pkg::*;
#(
	parameter int NUM_REGS  = 7,
	parameter int MEM_WORDS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         command,
	input  logic [2:0]         dest_reg,
	input  logic [1:0]         src_kind,
	input  logic [2:0]         src_reg,
	input  logic signed [15:0] immediate,
	input  logic [2:0]         shift_count,
	input  logic signed [15:0] io_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_value,
	output logic               overflow,
	output logic               underflow,
	output logic               carry,
	output logic               zero,
	output logic               div_error,
	output logic [15:0]        step_count
);

	localparam int RA_W = $clog2(NUM_REGS);
	localparam int MA_W = $clog2(MEM_WORDS);
	localparam bit MEM_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

	function automatic logic signed [FULL_W-1:0] zext8(input logic [DATA_W-1:0] v);
		return {{(FULL_W-DATA_W){1'b0}}, v};
	endfunction

	ebrm_state_t state_q, state_d;

	// latched item
	logic [3:0]              cmd_q;
	logic [2:0]              dst_q, srr_q, cnt_q;
	logic [1:0]              kind_q;
	logic signed [WORD_W-1:0] imm_q, iov_q;

	// operands
	logic [DATA_W-1:0] d_q, sreg_q, mval_q;
	logic [MA_W-1:0]   addr_q;

	// divider
	logic [DIV_W-1:0] rem_q, quo_q, dvs_q;
	logic [CNT_W-1:0] div_cnt_q;

	// ALU results
	logic signed [FULL_W-1:0] full_q;
	logic              flags_q, derr_q, reg_we_q, mem_we_q;
	logic [DATA_W-1:0] res_q;

	// valid bits and their registered read copies
	logic [NUM_REGS-1:0]  reg_valid_q;
	logic [MEM_WORDS-1:0] mem_valid_q;
	logic                 reg_rv_q, mem_rv_q;

	// output register and counter
	logic              out_valid_q, ovf_q, unf_q, zero_q, derr_out_q;
	logic [DATA_W-1:0] out_value_q;
	logic [15:0]       instr_count_q;

	// RAM ports
	logic [RA_W-1:0]   reg_raddr, reg_waddr;
	logic [DATA_W-1:0] reg_rdata;
	logic              reg_we;
	logic [MA_W-1:0]   mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	logic              mem_we;

	logic commit, out_free, div_load_addr, div_load_quo, div_step;

	ebrm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_reg_ram (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_waddr),
		.wdata (res_q),
		.raddr (reg_raddr),
		.rdata (reg_rdata)
	);

	ebrm_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_data_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr_q),
		.wdata (d_q),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// register index range checks; out-of-range reads give zero
	logic dst_ok, srr_ok;
	assign dst_ok = int'(dst_q) < NUM_REGS;
	assign srr_ok = int'(srr_q) < NUM_REGS;

	logic [DATA_W-1:0] d_now, sreg_now, mem_now;
	assign d_now    = (dst_ok && reg_rv_q) ? reg_rdata : '0;
	assign sreg_now = (srr_ok && reg_rv_q) ? reg_rdata : '0;
	assign mem_now  = mem_rv_q ? mem_rdata : '0;

	// command classes
	logic is_ldst, is_binop, need_addr;
	assign is_ldst  = (cmd_q == CMD_LOAD) || (cmd_q == CMD_STORE);
	assign is_binop = (cmd_q == CMD_MOV) || (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB)
		|| (cmd_q == CMD_MUL) || (cmd_q == CMD_DIV);
	assign need_addr = is_ldst || (is_binop && (kind_q != SRC_REG) && (kind_q != SRC_IMM));

	// memory address before reduction; masked form for power-of-two sizes
	logic [DIV_W-1:0] addr_src, addr_mask;
	assign addr_src  = (kind_q == SRC_IMM) ? $unsigned(imm_q) : {{(DIV_W-DATA_W){1'b0}}, sreg_now};
	assign addr_mask = {{(DIV_W-MA_W){1'b0}}, addr_src[MA_W-1:0]};

	// source operand
	logic signed [WORD_W-1:0] src_val;
	logic [WORD_W-1:0]        src_mag;
	logic                     src_neg;
	always_comb begin
		unique case (kind_q)
			SRC_REG: src_val = {{(WORD_W-DATA_W){1'b0}}, sreg_q};
			SRC_IMM: src_val = imm_q;
			default: src_val = {{(WORD_W-DATA_W){1'b0}}, mval_q};
		endcase
	end
	assign src_neg = src_val[WORD_W-1];
	assign src_mag = src_neg ? (~$unsigned(src_val) + 16'd1) : $unsigned(src_val);

	// one restoring divide step
	logic [DIV_W:0]   div_shift;
	logic [DIV_W+1:0] div_diff;
	logic             div_ge;
	logic [DIV_W-1:0] div_rem_n;
	assign div_shift = {rem_q, quo_q[DIV_W-1]};
	assign div_diff  = {1'b0, div_shift} - {2'b00, dvs_q};
	assign div_ge    = !div_diff[DIV_W+1];
	assign div_rem_n = div_ge ? div_diff[DIV_W-1:0] : div_shift[DIV_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_GET_D;
			ST_GET_D:    state_d = ST_GET_S;
			ST_GET_S: begin
				if (!need_addr) begin
					state_d = ST_SRC;
				end else if (MEM_POW2) begin
					state_d = ST_MEM_RD;
				end else begin
					state_d = ST_ADDR_DIV;
				end
			end
			ST_ADDR_DIV: if (div_cnt_q == CNT_W'(1)) state_d = ST_MEM_RD;
			ST_MEM_RD:   state_d = ST_MEM_DATA;
			ST_MEM_DATA: state_d = ST_SRC;
			ST_SRC: begin
				if ((cmd_q == CMD_DIV) && (src_val != '0)) begin
					state_d = ST_QUO_DIV;
				end else begin
					state_d = ST_ALU;
				end
			end
			ST_QUO_DIV:  if (div_cnt_q == CNT_W'(1)) state_d = ST_ALU;
			ST_ALU:      state_d = ST_EXEC;
			ST_EXEC:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		out_free      = !out_valid_q || !out_stall;
		commit        = (state_q == ST_EXEC) && out_free;
		reg_raddr     = (state_q == ST_IDLE) ? RA_W'(dest_reg) : RA_W'(srr_q);
		reg_waddr     = RA_W'(dst_q);
		reg_we        = commit && reg_we_q && dst_ok;
		mem_raddr     = MA_W'(rem_q);
		mem_we        = commit && mem_we_q;
		div_load_addr = (state_q == ST_GET_S) && need_addr;
		div_load_quo  = (state_q == ST_SRC) && (cmd_q == CMD_DIV) && (src_val != '0);
		div_step      = (state_q == ST_ADDR_DIV) || (state_q == ST_QUO_DIV);
	end

	// ALU on the gathered operands
	logic [2*DATA_W-1:0]      rol2, ror2;
	logic [DATA_W-1:0]        inc8, dec8, shl8, shr8;
	logic signed [FULL_W-1:0] mul_p, quo_ext;
	logic signed [FULL_W-1:0] full_c;
	logic                     flags_c, derr_c, reg_we_c, mem_we_c;
	logic [DATA_W-1:0]        res_c;

	assign rol2    = {d_q, d_q} << cnt_q;
	assign ror2    = {d_q, d_q} >> cnt_q;
	assign inc8    = d_q + 8'd1;
	assign dec8    = d_q - 8'd1;
	assign shl8    = d_q << cnt_q;
	assign shr8    = d_q >> cnt_q;
	assign mul_p   = $signed({1'b0, d_q}) * src_val;
	assign quo_ext = zext8(quo_q[DATA_W-1:0]);

	always_comb begin
		full_c   = '0;
		flags_c  = 1'b0;
		derr_c   = 1'b0;
		res_c    = d_q;
		reg_we_c = 1'b0;
		mem_we_c = 1'b0;
		unique case (cmd_q)
			CMD_IN:  begin full_c = FULL_W'(iov_q); flags_c = 1'b1; end
			CMD_OUT: ;
			CMD_MOV: begin full_c = FULL_W'(src_val); flags_c = 1'b1; end
			CMD_ADD: begin full_c = zext8(d_q) + FULL_W'(src_val); flags_c = 1'b1; end
			CMD_SUB: begin full_c = zext8(d_q) - FULL_W'(src_val); flags_c = 1'b1; end
			CMD_MUL: begin full_c = mul_p; flags_c = 1'b1; end
			CMD_DIV: begin
				if (src_val != '0) begin
					full_c  = src_neg ? -quo_ext : quo_ext;
					flags_c = 1'b1;
				end else begin
					derr_c = 1'b1;
				end
			end
			CMD_INC:   begin full_c = zext8(inc8); flags_c = 1'b1; end
			CMD_DEC:   begin full_c = zext8(dec8); flags_c = 1'b1; end
			CMD_ROL:   begin full_c = zext8(rol2[2*DATA_W-1:DATA_W]); flags_c = 1'b1; end
			CMD_ROR:   begin full_c = zext8(ror2[DATA_W-1:0]); flags_c = 1'b1; end
			CMD_SHL:   begin full_c = zext8(shl8); flags_c = 1'b1; end
			CMD_SHR:   begin full_c = zext8(shr8); flags_c = 1'b1; end
			CMD_LOAD:  begin res_c = mval_q; reg_we_c = 1'b1; end
			CMD_STORE: mem_we_c = 1'b1;
			default: ;
		endcase
		if (flags_c) begin
			res_c    = full_c[DATA_W-1:0];
			reg_we_c = 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			instr_count_q <= '0;
			reg_valid_q   <= '0;
			mem_valid_q   <= '0;
			div_cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q   <= 1'b1;
				instr_count_q <= instr_count_q + 16'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (reg_we) begin
				reg_valid_q[reg_waddr] <= 1'b1;
			end
			if (mem_we) begin
				mem_valid_q[addr_q] <= 1'b1;
			end
			if (div_load_addr) begin
				div_cnt_q <= CNT_W'(DIV_W);
			end else if (div_load_quo) begin
				div_cnt_q <= CNT_W'(DATA_W);
			end else if (div_step) begin
				div_cnt_q <= div_cnt_q - CNT_W'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		reg_rv_q <= reg_valid_q[reg_raddr];
		mem_rv_q <= mem_valid_q[mem_raddr];

		if ((state_q == ST_IDLE) && in_valid) begin
			cmd_q  <= command;
			dst_q  <= dest_reg;
			kind_q <= src_kind;
			srr_q  <= src_reg;
			imm_q  <= immediate;
			cnt_q  <= shift_count;
			iov_q  <= io_value;
		end
		if (state_q == ST_GET_D) d_q <= d_now;
		if (state_q == ST_GET_S) sreg_q <= sreg_now;
		if (state_q == ST_MEM_RD) addr_q <= MA_W'(rem_q);
		if (state_q == ST_MEM_DATA) mval_q <= mem_now;

		// shared divider: address remainder or quotient
		if (div_load_addr) begin
			rem_q <= MEM_POW2 ? addr_mask : '0;
			quo_q <= addr_src;
			dvs_q <= DIV_W'(MEM_WORDS);
		end else if (div_load_quo) begin
			rem_q <= '0;
			quo_q <= {d_q, {(DIV_W-DATA_W){1'b0}}};
			dvs_q <= src_mag;
		end else if (div_step) begin
			rem_q <= div_rem_n;
			quo_q <= {quo_q[DIV_W-2:0], div_ge};
		end

		if (state_q == ST_ALU) begin
			full_q   <= full_c;
			flags_q  <= flags_c;
			derr_q   <= derr_c;
			res_q    <= res_c;
			reg_we_q <= reg_we_c;
			mem_we_q <= mem_we_c;
		end

		// result register
		if (commit) begin
			out_value_q <= dst_ok ? res_q : '0;
			ovf_q       <= flags_q && (full_q > 255);
			unf_q       <= flags_q && (full_q < 0);
			zero_q      <= flags_q && (full_q == 0);
			derr_out_q  <= derr_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign overflow   = ovf_q;
	assign carry      = ovf_q;
	assign underflow  = unf_q;
	assign zero       = zero_q;
	assign div_error  = derr_out_q;
	assign step_count = instr_count_q;

	`EBRM_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state_q == ST_GET_D, "accepted item did not start")
	`EBRM_ASSERT_NXT(a_count_on_commit, commit, out_valid && (step_count == $past(instr_count_q) + 16'd1), "step count did not advance on commit")
	`EBRM_ASSERT_IMP(a_flag_pair, out_valid, !(overflow && underflow) && (carry == overflow), "inconsistent range flags")
	`EBRM_ASSERT_IMP(a_div_error_alone, out_valid && div_error, !overflow && !underflow && !zero, "flags set with divide error")
	`EBRM_ASSERT_IMP(a_write_on_commit, reg_we || mem_we, (state_q == ST_EXEC) && out_free, "state written outside commit")

endmodule
